### hdl/assert_macros.svh
// Assertion helpers, clocked on clk with reset rst_n active low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SRL_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication.
`define SRL_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

### hdl/srl_pkg.sv
`default_nettype none

package srl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_LIST   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [30:0] rec_key;
        logic [63:0] rec_label;
        logic [7:0]  rec_rank;
    } rec_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] out_key;
        logic [63:0] out_label;
        logic [7:0]  out_rank;
        logic        last;
    } rec_out_t;

    typedef struct packed {
        logic        valid;
        logic [30:0] key;
        logic [63:0] label;
        logic [7:0]  rank;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [30:0] key;
        logic [63:0] label;
        logic [7:0]  rank;
    } cell_ctl_t;

    typedef struct packed {
        logic ge;
        logic seen;
    } cell_flags_t;

endpackage

`default_nettype wire

### hdl/srl_cell.sv
`default_nettype none

module srl_cell
    import srl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cell_ctl_t   ctl,
    input  wire entry_t      left_ent,
    input  wire logic        left_ge,
    input  wire entry_t      right_ent,
    input  wire logic        before_in,
    output entry_t           ent,
    output cell_flags_t      flags
);

    entry_t ent_reg;
    entry_t ent_next;
    logic   hit;
    logic   ge;
    logic   seen;

    assign hit   = ent_reg.valid && (ent_reg.key == ctl.key);
    assign ge    = ent_reg.valid && (ent_reg.rank >= ctl.rank);
    assign seen  = before_in || hit;
    assign flags = cell_flags_t'({ge, seen});
    assign ent   = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (!ge)
                begin
                    if (left_ge)
                    begin
                        ent_next.valid = 1'b1;
                        ent_next.key   = ctl.key;
                        ent_next.label = ctl.label;
                        ent_next.rank  = ctl.rank;
                    end
                    else
                    begin
                        ent_next = left_ent;
                    end
                end
            end
            OP_DELETE:
            begin
                if (seen)
                begin
                    ent_next = right_ent;
                end
            end
            OP_ROTATE:
            begin
                ent_next = right_ent;
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
        end
    end

endmodule

`default_nettype wire

### hdl/sorted_record_list.sv
`default_nettype none

// Sorted table of up to CAPACITY records held in a row of cells, highest rank
// first, equal ranks in arrival order; the table is empty after reset. Insert
// and delete are accepted and busy stays low for them: the single result beat
// shows on rsp with done high in the cycle after start. A list request on a
// non-empty table holds busy high while the cell ring rotates once past cell
// 0; one beat per occupied entry streams out in table order, the final one
// marked by last. A list of an empty table gives one empty-status beat in the
// next cycle. Action code 3 is ignored. Beats cannot be held off.

module sorted_record_list
    import srl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire rec_in_t  req,
    output logic          busy,
    output logic          done,
    output rec_out_t      rsp
);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic               done_reg;
    logic               done_next;
    rec_out_t           rsp_reg;
    rec_out_t           rsp_next;

    cell_ctl_t          ctl;
    entry_t             cell_ent   [CAPACITY];
    cell_flags_t        cell_flags [CAPACITY];
    logic [CAPACITY-1:0] before_in;
    entry_t             found_ent;
    logic               accept;
    logic               full;
    logic               empty;
    logic               found;

    assign accept = start && (state_reg == S_IDLE);
    assign full   = cell_ent[CAPACITY-1].valid;
    assign empty  = !cell_ent[0].valid;
    assign found  = cell_flags[CAPACITY-1].seen;

    always_comb
    begin
        ctl.key   = req.rec_key;
        ctl.label = req.rec_label;
        ctl.rank  = req.rec_rank;
        if (state_reg == S_LIST)
            ctl.op = OP_ROTATE;
        else if (accept && (req.action == ACT_INSERT) && !full)
            ctl.op = OP_INSERT;
        else if (accept && (req.action == ACT_DELETE))
            ctl.op = OP_DELETE;
        else
            ctl.op = OP_HOLD;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_ent;
        entry_t right_ent;
        logic   left_ge;

        if (i == 0)
        begin : g_head
            assign left_ent     = '0;
            assign left_ge      = 1'b1;
            assign before_in[i] = 1'b0;
        end
        else
        begin : g_body
            assign left_ent     = cell_ent[i-1];
            assign left_ge      = cell_flags[i-1].ge;
            assign before_in[i] = cell_flags[i-1].seen;
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_ent = (ctl.op == OP_ROTATE) ? cell_ent[0] : entry_t'('0);
        end
        else
        begin : g_mid
            assign right_ent = cell_ent[i+1];
        end

        srl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .left_ent  (left_ent),
            .left_ge   (left_ge),
            .right_ent (right_ent),
            .before_in (before_in[i]),
            .ent       (cell_ent[i]),
            .flags     (cell_flags[i])
        );
    end

    always_comb
    begin
        found_ent = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_flags[i].seen && !before_in[i])
                found_ent = found_ent | cell_ent[i];
        end
    end

    always_comb
    begin
        rsp_next  = rsp_reg;
        done_next = 1'b0;
        if (accept)
        begin
            rsp_next      = '0;
            rsp_next.last = 1'b1;
            case (req.action)
                ACT_INSERT:
                begin
                    done_next       = 1'b1;
                    rsp_next.status = full ? ST_FULL : ST_OK;
                end
                ACT_DELETE:
                begin
                    done_next = 1'b1;
                    if (found)
                    begin
                        rsp_next.status    = ST_OK;
                        rsp_next.out_key   = found_ent.key;
                        rsp_next.out_label = found_ent.label;
                        rsp_next.out_rank  = found_ent.rank;
                    end
                    else
                    begin
                        rsp_next.status = ST_NOT_FOUND;
                    end
                end
                ACT_LIST:
                begin
                    if (empty)
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = ST_EMPTY;
                    end
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_LIST)
        begin
            // emit cell 0, advance the ring
            done_next          = cell_ent[0].valid;
            rsp_next.status    = ST_OK;
            rsp_next.out_key   = cell_ent[0].key;
            rsp_next.out_label = cell_ent[0].label;
            rsp_next.out_rank  = cell_ent[0].rank;
            rsp_next.last      = !cell_ent[1].valid || (cnt_reg == IDX_W'(CAPACITY - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            done_reg <= done_next;
            rsp_reg  <= rsp_next;
            if (accept && (req.action == ACT_LIST) && !empty)
            begin
                state_reg <= S_LIST;
                cnt_reg   <= '0;
            end
            else if (state_reg == S_LIST)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(CAPACITY - 1))
                    state_reg <= S_IDLE;
            end
        end
    end

    assign busy = (state_reg == S_LIST);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`include "assert_macros.svh"

    `SRL_ASSERT_IMP(a_err_is_last, done && (rsp.status != ST_OK), rsp.last)
    `SRL_ASSERT_IMP(a_head_prefix, !busy && cell_ent[1].valid, cell_ent[0].valid)
    `SRL_ASSERT_IMP(a_tail_prefix, !busy && cell_ent[CAPACITY-1].valid,
                    cell_ent[CAPACITY-2].valid)
    `SRL_ASSERT_NXT(a_insert_fills, accept && (req.action == ACT_INSERT), cell_ent[0].valid)
    `SRL_ASSERT_IMP(a_list_entry, $rose(busy), $past(start && (req.action == ACT_LIST)))

endmodule

`default_nettype wire
